/* rtl/core/rc_channel_frame_parser_assert.svh */
// ----------------------------------------------------------------------------
// rc channel frame parser assertion macros
// shared property forms for the parser's concurrent assertions
// ----------------------------------------------------------------------------
`ifndef RC_CHANNEL_FRAME_PARSER_ASSERT_SVH
`define RC_CHANNEL_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, off during reset
`define RCFP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcfp assertion failed");

// next-cycle implication, off during reset
`define RCFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcfp assertion failed");

`endif

/* rtl/core/rcfp_pkg.sv */
// ----------------------------------------------------------------------------
// rcfp_pkg
// types and constants shared by the rc channel frame parser
// ----------------------------------------------------------------------------
package rcfp_pkg;

   localparam int DEFAULT_MAX_PACKET = 32;
   localparam int MIN_PACKET         = 20;
   localparam int CHAN_FIRST         = 4;
   localparam int CHAN_COUNT         = 8;
   localparam int CHAN_IDX_W         = 3;
   localparam int CHAN_W             = 16;
   localparam int LEN_W              = 6;

   localparam logic [7:0] HDR0         = 8'hAA;
   localparam logic [7:0] HDR1         = 8'h55;
   localparam logic [7:0] CMD_CHANNELS = 8'h03;

   localparam logic [CHAN_W-1:0] CHAN_RESET [CHAN_COUNT] = '{
      16'd1500, 16'd1500, 16'd1500, 16'd1000,
      16'd1000, 16'd1000, 16'd1000, 16'd1000
   };

   typedef enum logic [2:0] {
      STAT_ACCEPTED  = 3'd0,
      STAT_BAD_HDR   = 3'd1,
      STAT_BAD_SUM   = 3'd2,
      STAT_OTHER_CMD = 3'd3,
      STAT_SHORT     = 3'd4,
      STAT_OVERSIZE  = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [LEN_W-1:0]  packet_length;
      logic [CHAN_W-1:0] channel_0;
      logic [CHAN_W-1:0] channel_1;
      logic [CHAN_W-1:0] channel_2;
      logic [CHAN_W-1:0] channel_3;
      logic [CHAN_W-1:0] channel_4;
      logic [CHAN_W-1:0] channel_5;
      logic [CHAN_W-1:0] channel_6;
      logic [CHAN_W-1:0] channel_7;
   } rsp_type;

   // one result leaving the parser
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } res_type;

endpackage

/* rtl/core/rc_channel_frame_parser.sv */
// ----------------------------------------------------------------------------
// rc_channel_frame_parser
// radio packet parser: header and additive checksum check, channel update
// ----------------------------------------------------------------------------
// Takes one packet byte per cycle while req_ready is high; the byte flagged
// last is the checksum and produces one registered result, holding a status,
// the packet length and all eight held channel values. Every byte is handled
// by an add and a few compares between the packet state registers and the
// result register, so the input runs at one item per clock while req_ready is
// high. A two-entry result buffer keeps bytes flowing while a result waits;
// req_ready drops only when both entries are full. Channel values from a
// channel command packet are staged as they arrive and copied to the held set
// only on acceptance; reset sets held channels 0-2 to 1500 and 3-7 to 1000.
module rc_channel_frame_parser #(
   parameter int MAX_PACKET = rcfp_pkg::DEFAULT_MAX_PACKET
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rcfp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rcfp_pkg::rsp_type rsp_data
);

   rcfp_pkg::res_type res;
   logic              fire;

   assign fire = req_valid && req_ready;

   rcfp_parse #(
      .MAX_PACKET (MAX_PACKET)
   ) u_parse (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (req_data),
      .res   (res)
   );

   rcfp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .res       (res),
      .space     (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/core/rcfp_parse.sv */
// ----------------------------------------------------------------------------
// rcfp_parse
// per-byte packet state, channel staging and held channel commit
// ----------------------------------------------------------------------------
module rcfp_parse #(
   parameter int MAX_PACKET = rcfp_pkg::DEFAULT_MAX_PACKET
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  rcfp_pkg::req_type req,
   output rcfp_pkg::res_type res
);

   localparam int PW = $clog2(MAX_PACKET + 1);
   localparam int CW = rcfp_pkg::CHAN_W;
   localparam int LW = rcfp_pkg::LEN_W;

   logic [PW-1:0] pos_ff, pos_in;
   logic [7:0]    sum_ff, sum_in;
   logic          hdr_bad_ff, hdr_bad_in;
   logic [7:0]    cmd_ff, cmd_in;
   logic [7:0]    pend_ff, pend_in;
   logic [CW-1:0] staged_ff [rcfp_pkg::CHAN_COUNT];
   logic [CW-1:0] staged_nx [rcfp_pkg::CHAN_COUNT];
   logic [CW-1:0] held_ff   [rcfp_pkg::CHAN_COUNT];
   logic [CW-1:0] held_in   [rcfp_pkg::CHAN_COUNT];

   logic [7:0]                      b;
   logic                            in_chan;
   logic [PW-1:0]                   off;
   logic [rcfp_pkg::CHAN_IDX_W-1:0] idx;
   logic                            stage_wr;
   rcfp_pkg::status_type            status;
   logic [LW-1:0]                   len;

   assign b        = req.data_byte;
   assign in_chan  = (pos_ff >= PW'(rcfp_pkg::CHAN_FIRST)) &&
                     (pos_ff < PW'(rcfp_pkg::CHAN_FIRST + 2 * rcfp_pkg::CHAN_COUNT));
   assign off      = pos_ff - PW'(rcfp_pkg::CHAN_FIRST);
   assign idx      = off[rcfp_pkg::CHAN_IDX_W:1];
   assign stage_wr = fire && in_chan && off[0];

   // staged view including this byte, so a low byte on the checksum is committed too
   always_comb begin
      for (int k = 0; k < rcfp_pkg::CHAN_COUNT; k++) begin
         staged_nx[k] = (stage_wr && idx == rcfp_pkg::CHAN_IDX_W'(k)) ? {pend_ff, b}
                                                                      : staged_ff[k];
      end
   end

   // header and command bytes sit well before any legal final byte
   always_comb begin
      if (pos_ff >= PW'(MAX_PACKET)) begin
         status = rcfp_pkg::STAT_OVERSIZE;
      end else if (pos_ff < PW'(rcfp_pkg::MIN_PACKET - 1)) begin
         status = rcfp_pkg::STAT_SHORT;
      end else if (hdr_bad_ff) begin
         status = rcfp_pkg::STAT_BAD_HDR;
      end else if (sum_ff != b) begin
         status = rcfp_pkg::STAT_BAD_SUM;
      end else if (cmd_ff != rcfp_pkg::CMD_CHANNELS) begin
         status = rcfp_pkg::STAT_OTHER_CMD;
      end else begin
         status = rcfp_pkg::STAT_ACCEPTED;
      end
   end

   assign len = (pos_ff >= PW'(MAX_PACKET)) ? LW'(MAX_PACKET) : LW'(pos_ff) + LW'(1);

   always_comb begin
      pos_in     = pos_ff;
      sum_in     = sum_ff;
      hdr_bad_in = hdr_bad_ff;
      cmd_in     = cmd_ff;
      pend_in    = pend_ff;
      for (int k = 0; k < rcfp_pkg::CHAN_COUNT; k++) begin
         held_in[k] = held_ff[k];
      end
      if (fire) begin
         if (req.last_byte) begin
            pos_in     = '0;
            sum_in     = '0;
            hdr_bad_in = 1'b0;
            cmd_in     = '0;
            pend_in    = '0;
            if (status == rcfp_pkg::STAT_ACCEPTED) begin
               for (int k = 0; k < rcfp_pkg::CHAN_COUNT; k++) begin
                  held_in[k] = staged_nx[k];
               end
            end
         end else begin
            sum_in = sum_ff + b;
            if (pos_ff < PW'(MAX_PACKET)) begin
               pos_in = pos_ff + PW'(1);
            end
            if ((pos_ff == PW'(0) && b != rcfp_pkg::HDR0) ||
                (pos_ff == PW'(1) && b != rcfp_pkg::HDR1)) begin
               hdr_bad_in = 1'b1;
            end
            if (pos_ff == PW'(2)) begin
               cmd_in = b;
            end
            if (in_chan && !off[0]) begin
               pend_in = b;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         sum_ff     <= '0;
         hdr_bad_ff <= 1'b0;
         cmd_ff     <= '0;
         pend_ff    <= '0;
         for (int k = 0; k < rcfp_pkg::CHAN_COUNT; k++) begin
            held_ff[k] <= rcfp_pkg::CHAN_RESET[k];
         end
      end else begin
         pos_ff     <= pos_in;
         sum_ff     <= sum_in;
         hdr_bad_ff <= hdr_bad_in;
         cmd_ff     <= cmd_in;
         pend_ff    <= pend_in;
         for (int k = 0; k < rcfp_pkg::CHAN_COUNT; k++) begin
            held_ff[k] <= held_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_wr) begin
         staged_ff[idx] <= {pend_ff, b};
      end
   end

   always_comb begin
      res.valid              = fire && req.last_byte;
      res.data.status        = status;
      res.data.packet_length = len;
      res.data.channel_0     = held_in[0];
      res.data.channel_1     = held_in[1];
      res.data.channel_2     = held_in[2];
      res.data.channel_3     = held_in[3];
      res.data.channel_4     = held_in[4];
      res.data.channel_5     = held_in[5];
      res.data.channel_6     = held_in[6];
      res.data.channel_7     = held_in[7];
   end

`include "rc_channel_frame_parser_assert.svh"

   `RCFP_ASSERT_NOW(a_pos_saturates, clock, reset, 1'b1, pos_ff <= PW'(MAX_PACKET))
   `RCFP_ASSERT_NEXT(a_end_clears, clock, reset, fire && req.last_byte, pos_ff == '0 && sum_ff == '0 && !hdr_bad_ff)
   `RCFP_ASSERT_NEXT(a_reject_keeps_held, clock, reset, fire && status != rcfp_pkg::STAT_ACCEPTED, held_ff[0] == $past(held_ff[0]) && held_ff[7] == $past(held_ff[7]))

endmodule

/* rtl/core/rcfp_out_buf.sv */
// ----------------------------------------------------------------------------
// rcfp_out_buf
// two-entry result register with skid stage
// ----------------------------------------------------------------------------
module rcfp_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  rcfp_pkg::res_type res,
   output logic              space,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rcfp_pkg::rsp_type rsp_data
);

   logic              main_valid_ff, main_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   rcfp_pkg::rsp_type main_ff, main_in;
   rcfp_pkg::rsp_type skid_ff, skid_in;
   logic              pop;

   assign pop       = main_valid_ff && rsp_ready;
   assign space     = !skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res.valid) begin
         if (!main_valid_ff || pop) begin
            main_in       = res.data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = res.data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

`include "rc_channel_frame_parser_assert.svh"

   `RCFP_ASSERT_NOW(a_skid_needs_main, clock, reset, skid_valid_ff, main_valid_ff)
   `RCFP_ASSERT_NOW(a_no_push_when_full, clock, reset, res.valid, !skid_valid_ff)
   `RCFP_ASSERT_NEXT(a_skid_moves_up, clock, reset, skid_valid_ff && rsp_ready, main_valid_ff && !skid_valid_ff && main_ff == $past(skid_ff))

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// rc channel frame parser testbench
// Sends radio packets one byte per item with bursty valid and a stalling
// result side. A model of the parser built into the bench predicts the
// status, length and held channels for every packet end; each result is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

   localparam int MAX_PKT      = rcfp_pkg::DEFAULT_MAX_PACKET;
   localparam int RANDOM_BYTES = 240;
   localparam int RANDOM_MIN   = 4;
   localparam int DRAIN_CYCLES = 12;
   localparam int LIMIT_CYCLES = 400000;

   // header faults for a built packet
   localparam int HDR_OK      = 0;
   localparam int HDR_FAULT_0 = 1;
   localparam int HDR_FAULT_1 = 2;

   // channel byte fill for a built packet
   localparam int FILL_RANDOM = 0;
   localparam int FILL_ZERO   = 1;
   localparam int FILL_ONES   = 2;

   // result side stall patterns
   localparam int READY_ALWAYS = 0;
   localparam int READY_COIN   = 1;
   localparam int READY_SPARSE = 2;
   localparam int READY_LONG   = 3;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   rcfp_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rcfp_pkg::rsp_type rsp_data;

   rc_channel_frame_parser u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   initial begin
      #(LIMIT_CYCLES * 20);
      $display("FAIL");
      $finish;
   end

   // parser state mirrored by the bench
   int           frame_pos;
   logic [7:0]   frame_sum;
   logic         hdr_wrong;
   logic [7:0]   frame_cmd;
   logic [7:0]   hi_byte;
   logic [15:0]  staged_chan [rcfp_pkg::CHAN_COUNT];
   logic [15:0]  held_chan [rcfp_pkg::CHAN_COUNT];

   rcfp_pkg::rsp_type pending_reports [$];
   int           bad_reports = 0;
   int           bytes_sent = 0;
   int           burst_left = 0;
   int           chan_fill = FILL_RANDOM;
   logic [7:0]   frame_bytes [$];

   task automatic clear_frame();
      frame_pos = 0;
      frame_sum = '0;
      hdr_wrong = 1'b0;
      frame_cmd = '0;
      hi_byte   = '0;
   endtask

   // advance the mirrored parser by one accepted byte
   task automatic parse_byte(input logic [7:0] b, input logic last);
      int                   pos;
      int                   off;
      int                   len;
      rcfp_pkg::status_type st;
      rcfp_pkg::rsp_type    rep;
      pos = frame_pos;
      if (pos == 0 && b != rcfp_pkg::HDR0) hdr_wrong = 1'b1;
      if (pos == 1 && b != rcfp_pkg::HDR1) hdr_wrong = 1'b1;
      if (pos == 2) frame_cmd = b;
      if (pos >= rcfp_pkg::CHAN_FIRST &&
          pos < rcfp_pkg::CHAN_FIRST + 2 * rcfp_pkg::CHAN_COUNT) begin
         off = pos - rcfp_pkg::CHAN_FIRST;
         if (off % 2 == 0) begin
            hi_byte = b;
         end else begin
            staged_chan[off / 2] = {hi_byte, b};
         end
      end
      if (!last) begin
         frame_sum = frame_sum + b;
         if (frame_pos < MAX_PKT) frame_pos++;
      end else begin
         len = pos + 1;
         if (pos >= MAX_PKT) st = rcfp_pkg::STAT_OVERSIZE;
         else if (len < rcfp_pkg::MIN_PACKET) st = rcfp_pkg::STAT_SHORT;
         else if (hdr_wrong) st = rcfp_pkg::STAT_BAD_HDR;
         else if (frame_sum != b) st = rcfp_pkg::STAT_BAD_SUM;
         else if (frame_cmd != rcfp_pkg::CMD_CHANNELS) st = rcfp_pkg::STAT_OTHER_CMD;
         else st = rcfp_pkg::STAT_ACCEPTED;
         if (st == rcfp_pkg::STAT_ACCEPTED) begin
            for (int k = 0; k < rcfp_pkg::CHAN_COUNT; k++) held_chan[k] = staged_chan[k];
         end
         if (len > MAX_PKT) len = MAX_PKT;
         rep.status        = st;
         rep.packet_length = len[rcfp_pkg::LEN_W-1:0];
         rep.channel_0     = held_chan[0];
         rep.channel_1     = held_chan[1];
         rep.channel_2     = held_chan[2];
         rep.channel_3     = held_chan[3];
         rep.channel_4     = held_chan[4];
         rep.channel_5     = held_chan[5];
         rep.channel_6     = held_chan[6];
         rep.channel_7     = held_chan[7];
         pending_reports.push_back(rep);
         clear_frame();
      end
   endtask

   // offer one item, idling between bursts
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(40, 120)
                                                : $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: b, last_byte: last};
      do @(posedge clock); while (!req_ready);
      parse_byte(b, last);
      bytes_sent++;
      burst_left--;
   endtask

   // build a packet of len bytes and send it, last byte flagged
   task automatic send_frame(input int len, input logic [7:0] cmd,
                             input int hdr_fault, input bit sum_ok);
      logic [7:0] b;
      logic [7:0] sum;
      frame_bytes.delete();
      sum = '0;
      for (int i = 0; i < len - 1; i++) begin
         if (i == 0) begin
            b = hdr_fault == HDR_FAULT_0 ? rcfp_pkg::HDR0 ^ 8'($urandom_range(1, 255))
                                         : rcfp_pkg::HDR0;
         end else if (i == 1) begin
            b = hdr_fault == HDR_FAULT_1 ? rcfp_pkg::HDR1 ^ 8'($urandom_range(1, 255))
                                         : rcfp_pkg::HDR1;
         end else if (i == 2) begin
            b = cmd;
         end else if (i >= rcfp_pkg::CHAN_FIRST && chan_fill == FILL_ZERO) begin
            b = 8'h00;
         end else if (i >= rcfp_pkg::CHAN_FIRST && chan_fill == FILL_ONES) begin
            b = 8'hFF;
         end else begin
            b = 8'($urandom_range(0, 255));
         end
         frame_bytes.push_back(b);
         sum = sum + b;
      end
      frame_bytes.push_back(sum_ok ? sum : sum ^ 8'($urandom_range(1, 255)));
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   // good frames with other commands straight after reset show the reset channel set
   task automatic test_other_command();
      send_frame(rcfp_pkg::MIN_PACKET, 8'h00, HDR_OK, 1'b1);
      send_frame(24, 8'hFF, HDR_OK, 1'b1);
   endtask

   // shortest and longest accepted frames, channel extremes
   task automatic test_accept();
      chan_fill = FILL_ONES;
      send_frame(rcfp_pkg::MIN_PACKET, rcfp_pkg::CMD_CHANNELS, HDR_OK, 1'b1);
      chan_fill = FILL_ZERO;
      send_frame(MAX_PKT, rcfp_pkg::CMD_CHANNELS, HDR_OK, 1'b1);
      chan_fill = FILL_RANDOM;
      send_frame(rcfp_pkg::MIN_PACKET, rcfp_pkg::CMD_CHANNELS, HDR_OK, 1'b1);
   endtask

   // too short wins over a bad header
   task automatic test_short();
      send_frame(1, rcfp_pkg::CMD_CHANNELS, HDR_OK, 1'b1);
      send_frame(rcfp_pkg::MIN_PACKET - 1, rcfp_pkg::CMD_CHANNELS, HDR_OK, 1'b1);
      send_frame(5, rcfp_pkg::CMD_CHANNELS, HDR_FAULT_0, 1'b0);
   endtask

   // one byte over the limit, and far over it with a good checksum
   task automatic test_oversize();
      send_frame(MAX_PKT + 1, rcfp_pkg::CMD_CHANNELS, HDR_OK, 1'b1);
      send_frame(MAX_PKT + 9, rcfp_pkg::CMD_CHANNELS, HDR_FAULT_1, 1'b1);
   endtask

   // header fault wins over a checksum fault
   task automatic test_bad_header();
      send_frame(rcfp_pkg::MIN_PACKET, rcfp_pkg::CMD_CHANNELS, HDR_FAULT_0, 1'b1);
      send_frame(26, rcfp_pkg::CMD_CHANNELS, HDR_FAULT_1, 1'b0);
   endtask

   task automatic test_bad_checksum();
      send_frame(rcfp_pkg::MIN_PACKET, rcfp_pkg::CMD_CHANNELS, HDR_OK, 1'b0);
      send_frame(MAX_PKT, 8'h42, HDR_OK, 1'b0);
   endtask

   // mostly well-formed channel frames, the rest broken or noise
   task automatic test_random();
      int         frames;
      int         pick;
      int         len;
      logic [7:0] cmd;
      int         fault;
      frames = 0;
      bytes_sent = 0;
      while (bytes_sent < RANDOM_BYTES || frames < RANDOM_MIN) begin
         pick = $urandom_range(0, 99);
         case ($urandom_range(0, 9))
            0: chan_fill = FILL_ZERO;
            1: chan_fill = FILL_ONES;
            default: chan_fill = FILL_RANDOM;
         endcase
         cmd = $urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255))
                                         : rcfp_pkg::CMD_CHANNELS;
         fault = $urandom_range(0, 7) == 0 ? $urandom_range(HDR_FAULT_0, HDR_FAULT_1)
                                           : HDR_OK;
         if (pick < 65) begin
            len = $urandom_range(rcfp_pkg::MIN_PACKET, MAX_PKT);
            send_frame(len, cmd, HDR_OK, 1'b1);
         end else if (pick < 77) begin
            len = $urandom_range(1, rcfp_pkg::MIN_PACKET - 1);
            send_frame(len, cmd, fault, 1'($urandom_range(0, 1)));
         end else if (pick < 84) begin
            len = $urandom_range(0, 3) == 0 ? $urandom_range(MAX_PKT + 1, 70)
                                            : $urandom_range(MAX_PKT + 1, MAX_PKT + 4);
            send_frame(len, cmd, fault, 1'($urandom_range(0, 1)));
         end else if (pick < 92) begin
            len = $urandom_range(rcfp_pkg::MIN_PACKET, MAX_PKT);
            send_frame(len, cmd, $urandom_range(HDR_FAULT_0, HDR_FAULT_1),
                       1'($urandom_range(0, 1)));
         end else begin
            len = $urandom_range(rcfp_pkg::MIN_PACKET, MAX_PKT);
            send_frame(len, cmd, HDR_OK, 1'b0);
         end
         frames++;
      end
   endtask

   // result side: check each item, then pick the next ready
   int ready_mode = READY_ALWAYS;
   int ready_cycle = 0;

   always @(posedge clock) begin
      rcfp_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            bad_reports++;
            if (bad_reports <= 10)
               $display("unexpected report: status %0d len %0d",
                        rsp_data.status, rsp_data.packet_length);
         end else begin
            want = pending_reports.pop_front();
            if (rsp_data.status !== want.status
                || rsp_data.packet_length !== want.packet_length
                || rsp_data.channel_0 !== want.channel_0
                || rsp_data.channel_1 !== want.channel_1
                || rsp_data.channel_2 !== want.channel_2
                || rsp_data.channel_3 !== want.channel_3
                || rsp_data.channel_4 !== want.channel_4
                || rsp_data.channel_5 !== want.channel_5
                || rsp_data.channel_6 !== want.channel_6
                || rsp_data.channel_7 !== want.channel_7) begin
               bad_reports++;
               if (bad_reports <= 10) begin
                  $display("report mismatch: status exp %0d got %0d, len exp %0d got %0d",
                           want.status, rsp_data.status,
                           want.packet_length, rsp_data.packet_length);
                  $display("  channels exp %h", want[8*rcfp_pkg::CHAN_W-1:0]);
                  $display("  channels got %h", rsp_data[8*rcfp_pkg::CHAN_W-1:0]);
               end
            end
         end
      end
      if (ready_cycle % 64 == 0) ready_mode = $urandom_range(READY_ALWAYS, READY_LONG);
      ready_cycle++;
      case (ready_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         READY_SPARSE: rsp_ready <= (ready_cycle % 5 == 0);
         default:      rsp_ready <= (ready_cycle % 16 >= 12);
      endcase
   end

   initial begin
      for (int k = 0; k < rcfp_pkg::CHAN_COUNT; k++) begin
         held_chan[k]   = rcfp_pkg::CHAN_RESET[k];
         staged_chan[k] = '0;
      end
      clear_frame();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_other_command();
      test_accept();
      test_short();
      test_oversize();
      test_bad_header();
      test_bad_checksum();
      test_random();

      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (bad_reports == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/rcfp_pkg.sv
rtl/core/rcfp_parse.sv
rtl/core/rcfp_out_buf.sv
rtl/core/rc_channel_frame_parser.sv
tb/testbench.sv
